// File: rtl/core/fenw_pkg.sv
// Shared types, codes and the microprogram ROM for the Fenwick range-sum table.
package fenw_pkg;

    // Field widths of the request and result transactions.
    localparam int REQ_W   = 2;
    localparam int LEFT_W  = 10;
    localparam int RIGHT_W = 11;
    localparam int DATA_W  = 64;

    // Default table depth.
    localparam int SIZE_DEF = 1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET = 2'd2;

    // Microprogram counter width.
    localparam int UPC_W = 4;

    // Walk index operations.
    localparam logic [2:0] IDX_HOLD     = 3'd0;
    localparam logic [2:0] IDX_LD_RIGHT = 3'd1;
    localparam logic [2:0] IDX_LD_LEFT  = 3'd2;
    localparam logic [2:0] IDX_LD_LEFT1 = 3'd3;
    localparam logic [2:0] IDX_WALK_DN  = 3'd4;
    localparam logic [2:0] IDX_WALK_UP  = 3'd5;

    // Accumulator operations.
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_CLEAR = 2'd1;
    localparam logic [1:0] ACC_ADD   = 2'd2;

    // Saved prefix operations.
    localparam logic [1:0] TMP_HOLD = 2'd0;
    localparam logic [1:0] TMP_SAVE = 2'd1;
    localparam logic [1:0] TMP_SUB  = 2'd2;

    // Update delta operations.
    localparam logic [1:0] DLT_HOLD     = 2'd0;
    localparam logic [1:0] DLT_LD_VALUE = 2'd1;
    localparam logic [1:0] DLT_LD_VMT   = 2'd2;

    // Jump conditions.
    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_WALK     = 2'd1;
    localparam logic [1:0] COND_OUT_BUSY = 2'd2;

    // Microprogram entry points and loop targets.
    localparam logic [UPC_W-1:0] UPC_ADD    = UPC_W'(0);
    localparam logic [UPC_W-1:0] UPC_ADD_UP = UPC_W'(1);
    localparam logic [UPC_W-1:0] UPC_SUM    = UPC_W'(2);
    localparam logic [UPC_W-1:0] UPC_SUM_D1 = UPC_W'(3);
    localparam logic [UPC_W-1:0] UPC_SUM_LL = UPC_W'(4);
    localparam logic [UPC_W-1:0] UPC_SUM_D2 = UPC_W'(5);
    localparam logic [UPC_W-1:0] UPC_SUM_EM = UPC_W'(6);
    localparam logic [UPC_W-1:0] UPC_SET    = UPC_W'(7);
    localparam logic [UPC_W-1:0] UPC_SET_D1 = UPC_W'(8);
    localparam logic [UPC_W-1:0] UPC_SET_LL = UPC_W'(9);
    localparam logic [UPC_W-1:0] UPC_SET_D2 = UPC_W'(10);
    localparam logic [UPC_W-1:0] UPC_SET_DF = UPC_W'(11);
    localparam logic [UPC_W-1:0] UPC_SET_DL = UPC_W'(12);
    localparam logic [UPC_W-1:0] UPC_SET_UP = UPC_W'(13);

    // One microinstruction.
    typedef struct packed {
        logic [2:0]       idx_op;
        logic [1:0]       acc_op;
        logic [1:0]       tmp_op;
        logic [1:0]       dlt_op;
        logic             emit;
        logic [1:0]       cond;
        logic [UPC_W-1:0] target;
        logic             last;
    } ucw_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic walk_active;
        logic out_busy;
    } ustat_t;

    localparam ucw_t UCW_NOP = '{IDX_HOLD, ACC_HOLD, TMP_HOLD, DLT_HOLD, 1'b0,
                                 COND_NONE, UPC_W'(0), 1'b1};

    // Microprogram ROM.
    function automatic ucw_t micro_rom(input logic [UPC_W-1:0] upc);
        ucw_t w;
        w = UCW_NOP;
        unique case (upc)
            // Point add: start at left+1, walk up adding the value.
            UPC_ADD:    w = '{IDX_LD_LEFT1, ACC_HOLD, TMP_HOLD, DLT_LD_VALUE, 1'b0,
                              COND_NONE, UPC_ADD, 1'b0};
            UPC_ADD_UP: w = '{IDX_WALK_UP, ACC_HOLD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_ADD_UP, 1'b1};
            // Range sum: prefix(right) - prefix(left).
            UPC_SUM:    w = '{IDX_LD_RIGHT, ACC_CLEAR, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_NONE, UPC_SUM, 1'b0};
            UPC_SUM_D1: w = '{IDX_WALK_DN, ACC_ADD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_SUM_D1, 1'b0};
            UPC_SUM_LL: w = '{IDX_LD_LEFT, ACC_CLEAR, TMP_SAVE, DLT_HOLD, 1'b0,
                              COND_NONE, UPC_SUM_LL, 1'b0};
            UPC_SUM_D2: w = '{IDX_WALK_DN, ACC_ADD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_SUM_D2, 1'b0};
            UPC_SUM_EM: w = '{IDX_HOLD, ACC_HOLD, TMP_HOLD, DLT_HOLD, 1'b1,
                              COND_OUT_BUSY, UPC_SUM_EM, 1'b1};
            // Point set: read the element, then add value minus element.
            UPC_SET:    w = '{IDX_LD_LEFT1, ACC_CLEAR, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_NONE, UPC_SET, 1'b0};
            UPC_SET_D1: w = '{IDX_WALK_DN, ACC_ADD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_SET_D1, 1'b0};
            UPC_SET_LL: w = '{IDX_LD_LEFT, ACC_CLEAR, TMP_SAVE, DLT_HOLD, 1'b0,
                              COND_NONE, UPC_SET_LL, 1'b0};
            UPC_SET_D2: w = '{IDX_WALK_DN, ACC_ADD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_SET_D2, 1'b0};
            UPC_SET_DF: w = '{IDX_HOLD, ACC_HOLD, TMP_SUB, DLT_HOLD, 1'b0,
                              COND_NONE, UPC_SET_DF, 1'b0};
            UPC_SET_DL: w = '{IDX_LD_LEFT1, ACC_HOLD, TMP_HOLD, DLT_LD_VMT, 1'b0,
                              COND_NONE, UPC_SET_DL, 1'b0};
            UPC_SET_UP: w = '{IDX_WALK_UP, ACC_HOLD, TMP_HOLD, DLT_HOLD, 1'b0,
                              COND_WALK, UPC_SET_UP, 1'b1};
            default:    w = UCW_NOP;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/fenw_mem.sv
// Partial-sum memory with a clearing sweep after reset.
module fenw_mem
    import fenw_pkg::*;
#(
    parameter int SIZE = SIZE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [$clog2(SIZE)-1:0]   rd_addr,
    output logic [DATA_W-1:0]         rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(SIZE)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]         wr_data,
    output logic                      clr_busy
);

    localparam int IW = $clog2(SIZE);

    logic [DATA_W-1:0] mem [SIZE];
    logic [DATA_W-1:0] rd_data_reg;
    logic [IW-1:0]     clr_addr_reg;
    logic [IW-1:0]     clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic              clr_last;

    // The sweep writes zero to one entry per cycle until the last one.
    assign clr_last = (clr_addr_reg == IW'(SIZE - 1));

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (clr_last)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Single write port, shared by the sweep and the update walk.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// File: rtl/core/fenw_seq.sv
// Microprogram sequencer: request dispatch, step counter and conditional jumps.
module fenw_seq
    import fenw_pkg::*;
#(
    parameter int SIZE = SIZE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [LEFT_W-1:0] left,
    input  logic              clr_busy,
    input  ustat_t            st,
    output ucw_t              cw
);

    localparam int LCW = ($clog2(SIZE) + 1 > LEFT_W) ? $clog2(SIZE) + 1 : LEFT_W;

    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             accept;
    logic             left_ok;
    logic             start;
    logic [UPC_W-1:0] entry;
    logic             jump;
    ucw_t             cw_rom;

    // A transaction is taken whenever no program runs and the sweep is over.
    assign in_ready = !busy_reg && !clr_busy;
    assign accept   = in_valid && in_ready;
    assign left_ok  = (LCW'(left) < LCW'(SIZE));

    // Pick the program; an out-of-table add or set and the unused code run nothing.
    always_comb
    begin
        start = 1'b0;
        entry = UPC_ADD;
        unique case (req_type)
            REQ_ADD:
            begin
                start = left_ok;
                entry = UPC_ADD;
            end
            REQ_SUM:
            begin
                start = 1'b1;
                entry = UPC_SUM;
            end
            REQ_SET:
            begin
                start = left_ok;
                entry = UPC_SET;
            end
            default:
            begin
                start = 1'b0;
                entry = UPC_ADD;
            end
        endcase
    end

    // Fetch the control word; idle cycles drive a no-op.
    assign cw_rom = micro_rom(upc_reg);
    assign cw     = busy_reg ? cw_rom : UCW_NOP;

    assign jump = ((cw_rom.cond == COND_WALK) && st.walk_active) ||
                  ((cw_rom.cond == COND_OUT_BUSY) && st.out_busy);

    // Next step: jump, finish, or fall through.
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg)
        begin
            if (accept && start)
            begin
                busy_next = 1'b1;
                upc_next  = entry;
            end
        end
        else
        begin
            priority if (jump)
            begin
                upc_next = cw_rom.target;
            end
            else if (cw_rom.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

endmodule

// File: rtl/core/fenw_dp.sv
// Datapath: walk index, accumulators, output register and the partial-sum memory.
module fenw_dp
    import fenw_pkg::*;
#(
    parameter int SIZE = SIZE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_accept,
    input  logic [LEFT_W-1:0]         left,
    input  logic [RIGHT_W-1:0]        right,
    input  logic signed [DATA_W-1:0]  value,
    input  ucw_t                      cw,
    output ustat_t                    st,
    output logic                      clr_busy,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DATA_W-1:0]  range_total
);

    localparam int IW    = $clog2(SIZE);
    localparam int WW    = $clog2(SIZE) + 2;
    localparam int CMP_W = (WW > RIGHT_W) ? WW : RIGHT_W;

    logic [WW-1:0]     idx_reg;
    logic [WW-1:0]     idx_next;
    logic [WW-1:0]     left_sat_reg;
    logic [WW-1:0]     right_sat_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] tmp_reg;
    logic [DATA_W-1:0] tmp_next;
    logic [DATA_W-1:0] delta_reg;
    logic [DATA_W-1:0] delta_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              rd_pend_reg;
    logic              wr_pend_reg;
    logic [IW-1:0]     wr_addr_reg;

    logic [CMP_W-1:0]  left_ext;
    logic [CMP_W-1:0]  right_ext;
    logic [CMP_W-1:0]  left_sat;
    logic [CMP_W-1:0]  right_sat;
    logic [WW-1:0]     low_bit;
    logic [WW-1:0]     idx_m1;
    logic              dn_active;
    logic              up_active;
    logic              walk_active;
    logic              rd_en;
    logic              out_busy;
    logic              emit_fire;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] wr_data;

    // Prefix lengths above the table depth saturate to the depth.
    assign left_ext  = CMP_W'(left);
    assign right_ext = CMP_W'(right);
    assign left_sat  = (left_ext > CMP_W'(SIZE)) ? CMP_W'(SIZE) : left_ext;
    assign right_sat = (right_ext > CMP_W'(SIZE)) ? CMP_W'(SIZE) : right_ext;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_sat_reg  <= left_sat[WW-1:0];
            right_sat_reg <= right_sat[WW-1:0];
            value_reg     <= value;
        end
    end

    // Fenwick index arithmetic.
    assign low_bit   = idx_reg & (~idx_reg + WW'(1));
    assign idx_m1    = idx_reg - WW'(1);
    assign dn_active = (idx_reg != '0);
    assign up_active = (idx_reg <= WW'(SIZE));

    always_comb
    begin
        walk_active = 1'b0;
        if (cw.idx_op == IDX_WALK_DN)
        begin
            walk_active = dn_active;
        end
        else if (cw.idx_op == IDX_WALK_UP)
        begin
            walk_active = up_active;
        end
    end

    // Every active walk step reads the node it stands on.
    assign rd_en = walk_active;

    always_comb
    begin
        idx_next = idx_reg;
        unique case (cw.idx_op)
            IDX_HOLD:     idx_next = idx_reg;
            IDX_LD_RIGHT: idx_next = right_sat_reg;
            IDX_LD_LEFT:  idx_next = left_sat_reg;
            IDX_LD_LEFT1: idx_next = left_sat_reg + WW'(1);
            IDX_WALK_DN:  idx_next = dn_active ? (idx_reg - low_bit) : idx_reg;
            IDX_WALK_UP:  idx_next = up_active ? (idx_reg + low_bit) : idx_reg;
            default:      idx_next = idx_reg;
        endcase
    end

    // Prefix accumulator adds the node read in the previous step.
    always_comb
    begin
        acc_next = acc_reg;
        unique case (cw.acc_op)
            ACC_HOLD:  acc_next = acc_reg;
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = rd_pend_reg ? (acc_reg + rd_data) : acc_reg;
            default:   acc_next = acc_reg;
        endcase
    end

    // Saved first prefix, later the difference of the two prefixes.
    always_comb
    begin
        tmp_next = tmp_reg;
        unique case (cw.tmp_op)
            TMP_HOLD: tmp_next = tmp_reg;
            TMP_SAVE: tmp_next = acc_reg;
            TMP_SUB:  tmp_next = tmp_reg - acc_reg;
            default:  tmp_next = tmp_reg;
        endcase
    end

    // Amount added along the update walk.
    always_comb
    begin
        delta_next = delta_reg;
        unique case (cw.dlt_op)
            DLT_HOLD:     delta_next = delta_reg;
            DLT_LD_VALUE: delta_next = value_reg;
            DLT_LD_VMT:   delta_next = value_reg - tmp_reg;
            default:      delta_next = delta_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        delta_reg   <= delta_next;
        wr_addr_reg <= idx_m1[IW-1:0];
    end

    // Read-modify-write of the update walk: the write is issued in the cycle after its read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en && (cw.idx_op == IDX_WALK_DN);
            wr_pend_reg <= rd_en && (cw.idx_op == IDX_WALK_UP);
        end
    end

    assign wr_data = rd_data + delta_reg;

    fenw_mem #(
        .SIZE (SIZE)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (idx_m1[IW-1:0]),
        .rd_data  (rd_data),
        .wr_en    (wr_pend_reg),
        .wr_addr  (wr_addr_reg),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    // Output register; a new result may replace one taken in the same cycle.
    assign out_busy  = out_valid_reg && !out_ready;
    assign emit_fire = cw.emit && !out_busy;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= tmp_reg - acc_reg;
        end
    end

    assign st.walk_active = walk_active;
    assign st.out_busy    = out_busy;
    assign out_valid      = out_valid_reg;
    assign range_total    = out_data_reg;

endmodule

// File: rtl/core/fenwick_range_sum_table.sv
// Top level of the Fenwick range-sum table.
//
// Keeps SIZE signed 64-bit elements as Fenwick partial sums in one memory with
// one read and one write port. Requests arrive on the in channel (req_type,
// left, right, value) under valid/ready; a range sum returns one transaction
// on the out channel (range_total), point add and point set return nothing.
// Point adds and point sets beyond the table, and the unused request code, are
// accepted and dropped.
//
// A microcoded sequencer runs one request at a time. A walk reads one tree node
// per cycle and ends on a step that finds no node left. A range sum's result
// is valid at the edge that ends its program. in_ready is high again in the
// cycle after the last step.
//
// After reset the memory is swept to zero, one entry per cycle, and in_ready
// stays low during the sweep. A finished result waits in the output register;
// while it waits, the next range sum holds in its last step with in_ready low.
module fenwick_range_sum_table
    import fenw_pkg::*;
#(
    parameter int SIZE = SIZE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [REQ_W-1:0]          req_type,
    input  logic [LEFT_W-1:0]         left,
    input  logic [RIGHT_W-1:0]        right,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DATA_W-1:0]  range_total
);

    ucw_t   cw;
    ustat_t st;
    logic   clr_busy;
    logic   in_accept;

    assign in_accept = in_valid && in_ready;

    // Sequencer: dispatch and microprogram stepping.
    fenw_seq #(
        .SIZE (SIZE)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .left     (left),
        .clr_busy (clr_busy),
        .st       (st),
        .cw       (cw)
    );

    // Datapath with the partial-sum memory.
    fenw_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .left        (left),
        .right       (right),
        .value       (value),
        .cw          (cw),
        .st          (st),
        .clr_busy    (clr_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .range_total (range_total)
    );

endmodule

// File: dv/fenwick_range_sum_table_tb.sv
// Self-checking testbench for the Fenwick range-sum table: random and directed requests.
`timescale 1ns / 100ps

module fenwick_range_sum_table_tb;
    import fenw_pkg::*;

    // The one request code that the block accepts and drops.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = SIZE_DEF;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int DRAIN_CYCLES = 60;

    // Keeps a plain copy of every element and the range totals still owed by the block.
    class fenwick_scoreboard;
        bit [DATA_W-1:0] element [TABLE_DEPTH];
        bit [DATA_W-1:0] pending_totals [$];
        int failures;

        function new();
            foreach (element[k])
                element[k] = '0;
            failures = 0;
        endfunction

        // Sum of elements [0, n); a length above the table depth saturates.
        function bit [DATA_W-1:0] prefix_sum(int unsigned n);
            bit [DATA_W-1:0] acc;
            acc = '0;
            if (n > TABLE_DEPTH)
                n = TABLE_DEPTH;
            for (int unsigned k = 0; k < n; k++)
                acc += element[k];
            return acc;
        endfunction

        // Applies one accepted request to the element copy, or queues the total a range sum owes.
        function void note_request(bit [REQ_W-1:0] rq, bit [LEFT_W-1:0] l,
                                   bit [RIGHT_W-1:0] r, bit [DATA_W-1:0] v);
            bit [DATA_W-1:0] total;
            case (rq)
                REQ_ADD: element[l] += v;
                REQ_SUM:
                begin
                    total = prefix_sum(r) - prefix_sum(l);
                    pending_totals = {pending_totals, total};
                end
                REQ_SET: element[l] = v;
                default: ;
            endcase
        endfunction

        // Compares one result transaction against the oldest owed total.
        function void check_total(bit [DATA_W-1:0] actual);
            bit [DATA_W-1:0] expected;
            if (pending_totals.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected range_total %h", $realtime, actual);
                return;
            end
            expected = pending_totals.pop_front();
            if (actual !== expected)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: range_total mismatch: expected %h, actual %h",
                             $realtime, expected, actual);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [REQ_W-1:0]         req_type;
    logic [LEFT_W-1:0]        left;
    logic [RIGHT_W-1:0]       right;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] range_total;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    fenwick_scoreboard totals_sb = new();

    fenwick_range_sum_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .left        (left),
        .right       (right),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .range_total (range_total)
    );

    // Free-running 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watches both channels; a request is noted before any result of the same edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            totals_sb.note_request(req_type, left, right, value);
        if (rst_n && out_valid && out_ready)
            totals_sb.check_total(range_total);
    end

    // Offers one request transaction after an optional random gap and waits for acceptance.
    task automatic send_request(input bit [REQ_W-1:0] rq, input bit [LEFT_W-1:0] l,
                                input bit [RIGHT_W-1:0] r, input bit [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        left     <= l;
        right    <= r;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Values lean on the extremes and small numbers as well as full-width noise.
    function automatic bit [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'h7fff_ffff_ffff_ffff;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'(signed'($urandom_range(0, 200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Indices cluster in a small window so that updates and queries overlap often.
    function automatic bit [LEFT_W-1:0] pick_index();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return LEFT_W'(TABLE_DEPTH - 1);
            2, 3: return LEFT_W'($urandom_range(0, 15));
            default: return LEFT_W'($urandom_range(0, TABLE_DEPTH - 1));
        endcase
    endfunction

    // Range ends mostly inside the table, sometimes past it.
    function automatic bit [RIGHT_W-1:0] pick_end();
        case ($urandom_range(0, 7))
            0: return RIGHT_W'(TABLE_DEPTH);
            1: return RIGHT_W'($urandom_range(TABLE_DEPTH + 1, 2047));
            2, 3: return RIGHT_W'($urandom_range(0, 16));
            default: return RIGHT_W'($urandom_range(0, TABLE_DEPTH));
        endcase
    endfunction

    // Main sequence: reset, directed requests, three random phases, drain.
    initial
    begin
        int counted;
        int unsigned pick;
        bit [REQ_W-1:0] rq;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= '0;
        left          <= '0;
        right         <= '0;
        value         <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, every request kind, reversed and oversized ranges.
        send_request(REQ_SUM, 10'd0, 11'd1024, 64'd0);
        send_request(REQ_ADD, 10'd0, 11'd0, 64'h7fff_ffff_ffff_ffff);
        send_request(REQ_ADD, 10'd1023, 11'd2047, 64'h8000_0000_0000_0000);
        send_request(REQ_ADD, 10'd511, 11'd0, 64'hffff_ffff_ffff_ffff);
        send_request(REQ_SUM, 10'd0, 11'd1024, 64'd0);
        send_request(REQ_SUM, 10'd0, 11'd1, 64'hffff_ffff_ffff_ffff);
        send_request(REQ_SUM, 10'd1023, 11'd1024, 64'd0);
        send_request(REQ_SUM, 10'd1023, 11'd0, 64'd0);
        send_request(REQ_SUM, 10'd0, 11'd0, 64'd0);
        send_request(REQ_SUM, 10'd512, 11'd2047, 64'd0);
        send_request(REQ_SUM, 10'd1023, 11'd1025, 64'd0);
        send_request(REQ_SET, 10'd511, 11'd0, 64'd5);
        send_request(REQ_SUM, 10'd511, 11'd512, 64'd0);
        send_request(REQ_SET, 10'd0, 11'd0, 64'h8000_0000_0000_0000);
        send_request(REQ_SET, 10'd1023, 11'd2047, 64'd0);
        send_request(REQ_UNUSED, 10'd1023, 11'd2047, 64'hffff_ffff_ffff_ffff);
        send_request(REQ_SUM, 10'd0, 11'd1024, 64'd0);
        send_request(REQ_ADD, 10'd0, 11'd0, 64'h8000_0000_0000_0000);
        send_request(REQ_ADD, 10'd0, 11'd0, 64'h8000_0000_0000_0000);
        send_request(REQ_SUM, 10'd0, 11'd1, 64'd0);
        send_request(REQ_SET, 10'd511, 11'd0, 64'd5);
        send_request(REQ_SUM, 10'd1023, 11'd511, 64'd0);

        // Random phases: receiver-heavy idling, sender-heavy idling, then none.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    rq = REQ_ADD;
                else if (pick < 70)
                    rq = REQ_SUM;
                else if (pick < 95)
                    rq = REQ_SET;
                else
                    rq = REQ_UNUSED;
                send_request(rq, pick_index(), pick_end(), pick_value());
                if (rq != REQ_UNUSED)
                    counted++;
            end
        end

        // Drain: wait for every owed total, then let the block settle.
        in_valid <= 1'b0;
        while (totals_sb.pending_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (totals_sb.failures == 0 && totals_sb.pending_totals.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fenw_pkg.sv
rtl/core/fenw_mem.sv
rtl/core/fenw_seq.sv
rtl/core/fenw_dp.sv
rtl/core/fenwick_range_sum_table.sv
dv/fenwick_range_sum_table_tb.sv
